@@ rtl/cshr_pkg.sv @@
// shared constants, types and helpers of the caseless substring hit reporter
`default_nettype none
package cshr_pkg;

    localparam int QUERY_MAX  = 64;
    localparam int LINE_MAX   = 1024;
    localparam int COUNT_BITS = 16;

    localparam int LEN_W  = $clog2(QUERY_MAX + 1);
    localparam int COL_W  = $clog2(LINE_MAX + 1);
    localparam int CMP_W  = (COL_W > LEN_W) ? COL_W : LEN_W;
    localparam int POS_W  = 10;
    localparam int VS_W   = (CMP_W > POS_W) ? CMP_W : POS_W;
    localparam int HIST_D = (QUERY_MAX > 1) ? QUERY_MAX - 1 : 1;

    localparam logic [COL_W-1:0] LINE_LIMIT = COL_W'(LINE_MAX);
    localparam logic [LEN_W-1:0] QUERY_FULL = LEN_W'(QUERY_MAX);

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_TEXT    = 2'd2,
        FUNC_ROW_END = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        VS_BEFORE = 2'd0,
        VS_AT     = 2'd1,
        VS_AFTER  = 2'd2
    } t_vs;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic       push;
        logic [7:0] data;
    } t_win_cmd;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] len;
    } t_win_stat;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/cshr_ifs.sv @@
// item channel interfaces of the caseless substring hit reporter
`default_nettype none
interface cshr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [9:0] search_origin;

    modport source (output valid, func, data_byte, search_origin, input ready);
    modport sink   (input valid, func, data_byte, search_origin, output ready);
endinterface

interface cshr_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [9:0]  hit_pos;
    logic [1:0]  hit_vs_origin;
    logic [9:0]  hit_index;
    logic [15:0] total_ordinal;
    logic [15:0] row_number;
    logic        row_done;
    logic [10:0] row_hits;

    modport source (output valid, hit, hit_pos, hit_vs_origin, hit_index,
                    total_ordinal, row_number, row_done, row_hits, input ready);
    modport sink   (input valid, hit, hit_pos, hit_vs_origin, hit_index,
                    total_ordinal, row_number, row_done, row_hits, output ready);
endinterface
`default_nettype wire

@@ rtl/caseless_substring_hit_reporter.sv @@
// top level of the caseless substring hit reporter
//
//  channel   dir  handshake     payload
//  i_item    in   valid/ready   func, data_byte, search_origin
//  o_result  out  valid/ready   hit, hit_pos, hit_vs_origin, hit_index,
//                               total_ordinal, row_number, row_done, row_hits
//
// one item per cycle unless stalled; text byte and row end results register on accept
// the whole window compare and counter update sit between the input and result register
// clear and query append give no result and only update state
// i_item.ready drops only while a result waits and o_result.ready is low
// synchronous active-low reset empties the query and zeroes column and counters
`default_nettype none
module caseless_substring_hit_reporter (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cshr_in_if.sink      i_item,
    cshr_out_if.source   o_result
);

    logic                            w_acc;
    cshr_pkg::t_func                 w_func;
    cshr_pkg::t_win_cmd              w_cmd;
    cshr_pkg::t_win_stat             w_stat;
    logic [cshr_pkg::COL_W-1:0]      w_col_inc;
    logic [cshr_pkg::CMP_W-1:0]      w_start;
    logic                            w_hit;
    logic                            w_result;
    cshr_pkg::t_vs                   w_vs;

    logic [cshr_pkg::COL_W-1:0]      r_column,   n_column;
    logic [cshr_pkg::COL_W-1:0]      r_row_hits, n_row_hits;
    logic [cshr_pkg::COUNT_BITS-1:0] r_total,    n_total;
    logic [cshr_pkg::COUNT_BITS-1:0] r_row,      n_row;
    logic                            r_valid;

    logic        r_hit;
    logic [9:0]  r_hit_pos;
    logic [1:0]  r_hit_vs;
    logic [9:0]  r_row_occ;
    logic [15:0] r_total_ord;
    logic [15:0] r_row_number;
    logic        r_row_done;
    logic [10:0] r_row_hits_out;

    assign i_item.ready = !r_valid || o_result.ready;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_func       = cshr_pkg::t_func'(i_item.func);

    assign w_cmd.clear  = w_acc && (w_func == cshr_pkg::FUNC_CLEAR);
    assign w_cmd.append = w_acc && (w_func == cshr_pkg::FUNC_APPEND);
    assign w_cmd.push   = w_acc && (w_func == cshr_pkg::FUNC_TEXT)
                          && (r_column < cshr_pkg::LINE_LIMIT);
    assign w_cmd.data   = i_item.data_byte;
    assign w_result     = w_acc && (w_func == cshr_pkg::FUNC_TEXT
                                    || w_func == cshr_pkg::FUNC_ROW_END);

    cshr_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    assign w_col_inc = r_column + 1'b1;
    assign w_start   = cshr_pkg::CMP_W'(w_col_inc) - cshr_pkg::CMP_W'(w_stat.len);
    assign w_hit     = w_cmd.push && w_stat.hit
                       && (cshr_pkg::CMP_W'(w_col_inc) >= cshr_pkg::CMP_W'(w_stat.len));

    always_comb begin
        if (cshr_pkg::VS_W'(w_start) < cshr_pkg::VS_W'(i_item.search_origin)) begin
            w_vs = cshr_pkg::VS_BEFORE;
        end else if (cshr_pkg::VS_W'(w_start) == cshr_pkg::VS_W'(i_item.search_origin)) begin
            w_vs = cshr_pkg::VS_AT;
        end else begin
            w_vs = cshr_pkg::VS_AFTER;
        end
    end

    always_comb begin
        n_column   = r_column;
        n_row_hits = r_row_hits;
        n_total    = r_total;
        n_row      = r_row;
        if (w_acc) begin
            case (w_func)
                cshr_pkg::FUNC_CLEAR: begin
                    n_column   = '0;
                    n_row_hits = '0;
                    n_total    = '0;
                    n_row      = '0;
                end
                cshr_pkg::FUNC_APPEND: begin
                end
                cshr_pkg::FUNC_TEXT: begin
                    if (w_cmd.push) begin
                        n_column = w_col_inc;
                    end
                    if (w_hit) begin
                        if (r_row_hits < cshr_pkg::LINE_LIMIT) begin
                            n_row_hits = r_row_hits + 1'b1;
                        end
                        if (!(&r_total)) begin
                            n_total = r_total + 1'b1;
                        end
                    end
                end
                cshr_pkg::FUNC_ROW_END: begin
                    n_column   = '0;
                    n_row_hits = '0;
                    if (!(&r_row)) begin
                        n_row = r_row + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= '0;
            r_row_hits <= '0;
            r_total    <= '0;
            r_row      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_column   <= n_column;
            r_row_hits <= n_row_hits;
            r_total    <= n_total;
            r_row      <= n_row;
            if (w_result) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_hit          <= w_hit;
            r_hit_pos      <= w_hit ? 10'(w_start) : 10'd0;
            r_hit_vs       <= w_hit ? w_vs : cshr_pkg::VS_BEFORE;
            r_row_occ      <= w_hit ? 10'(r_row_hits) : 10'd0;
            r_total_ord    <= w_hit ? 16'(n_total) : 16'd0;
            r_row_number   <= 16'(r_row);
            r_row_done     <= (w_func == cshr_pkg::FUNC_ROW_END);
            r_row_hits_out <= (w_func == cshr_pkg::FUNC_ROW_END) ? 11'(r_row_hits) : 11'd0;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.hit            = r_hit;
    assign o_result.hit_pos        = r_hit_pos;
    assign o_result.hit_vs_origin  = r_hit_vs;
    assign o_result.hit_index      = r_row_occ;
    assign o_result.total_ordinal  = r_total_ord;
    assign o_result.row_number     = r_row_number;
    assign o_result.row_done       = r_row_done;
    assign o_result.row_hits       = r_row_hits_out;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_result.ready |-> !i_item.ready)
        else $error("input accepted while a result is stalled");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> r_total == '0 && r_row == '0 && r_column == '0)
        else $error("clear left counters set");

    a_hit_not_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_hit && r_row_done))
        else $error("hit reported on a row end result");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_hit |-> r_hit_pos == '0 && r_row_occ == '0 && r_total_ord == '0)
        else $error("hit fields set without a hit");

endmodule
`default_nettype wire

@@ rtl/cshr_match.sv @@
// reversed query lanes, text history and parallel window compare
`default_nettype none
module cshr_match (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cshr_pkg::t_win_cmd i_cmd,
    output cshr_pkg::t_win_stat     o_stat
);

    // r_qrev[a] holds the query byte that lines up with the text byte of age a
    logic [7:0]                   r_qrev   [cshr_pkg::QUERY_MAX];
    logic [7:0]                   r_recent [cshr_pkg::HIST_D];
    logic [cshr_pkg::LEN_W-1:0]   r_len;
    logic [cshr_pkg::QUERY_MAX-1:0] w_lane_ok;
    logic [7:0]                   w_fold;

    assign w_fold = cshr_pkg::fold_case(i_cmd.data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.clear) begin
            r_len <= '0;
        end else if (i_cmd.append && r_len != cshr_pkg::QUERY_FULL) begin
            r_len <= r_len + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && r_len != cshr_pkg::QUERY_FULL) begin
            r_qrev[0] <= w_fold;
            for (int a = 1; a < cshr_pkg::QUERY_MAX; a++) begin
                r_qrev[a] <= r_qrev[a-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_recent[0] <= w_fold;
            for (int a = 1; a < cshr_pkg::HIST_D; a++) begin
                r_recent[a] <= r_recent[a-1];
            end
        end
    end

    // lane a compares against the window as it stands after the new byte
    for (genvar a = 0; a < cshr_pkg::QUERY_MAX; a++) begin : g_lane
        if (a == 0) begin : g_new
            assign w_lane_ok[a] = (r_qrev[a] == w_fold)
                                  || !(cshr_pkg::LEN_W'(a) < r_len);
        end else begin : g_old
            assign w_lane_ok[a] = (r_qrev[a] == r_recent[a-1])
                                  || !(cshr_pkg::LEN_W'(a) < r_len);
        end
    end

    assign o_stat.hit = (r_len != '0) && (&w_lane_ok);
    assign o_stat.len = r_len;

endmodule
`default_nettype wire
